FILE: hw/rtl/iwdt_pkg.sv
package iwdt_pkg;

    localparam int DEFAULT_WINDOW_ENTRIES = 32;

    // producer indexes inside the ring are carried at the widest window size
    localparam int ENTRY_IDX_W = 8;
    localparam int REG_W       = 7;
    localparam int KIND_W      = 2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STORE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // search token handed from cell to cell, older entries next
    typedef struct packed {
        logic                   src1_used;
        logic [REG_W-1:0]       src1_reg;
        logic                   src2_used;
        logic [REG_W-1:0]       src2_reg;
        logic                   is_load;
        logic                   src1_found;
        logic [ENTRY_IDX_W-1:0] src1_producer;
        logic                   src2_found;
        logic [ENTRY_IDX_W-1:0] src2_producer;
        logic                   mem_found;
        logic [ENTRY_IDX_W-1:0] mem_producer;
    } token_t;

    // entry update broadcast to all cells, taken by the selected one
    typedef struct packed {
        logic             add;
        logic             remove;
        logic             has_dest;
        logic [REG_W-1:0] dest_reg;
        logic             is_store;
    } entry_wr_t;

endpackage

FILE: hw/rtl/iwdt_cell.sv
module iwdt_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               sel,
    input  iwdt_pkg::entry_wr_t wr,
    input  logic               inject,
    input  iwdt_pkg::token_t   start_tok,
    input  iwdt_pkg::token_t   tok_in,
    output iwdt_pkg::token_t   tok_out
);
    import iwdt_pkg::*;

    logic             valid_reg;
    logic             has_dest_reg;
    logic [REG_W-1:0] dest_reg_reg;
    logic             is_store_reg;
    token_t           tok_reg;
    token_t           tok_cur;
    token_t           tok_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (sel && wr.add) begin
            valid_reg <= 1'b1;
        end else if (sel && wr.remove) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sel && wr.add) begin
            has_dest_reg <= wr.has_dest;
            dest_reg_reg <= wr.dest_reg;
            is_store_reg <= wr.is_store;
        end
    end

    always_comb begin
        tok_cur  = inject ? start_tok : tok_in;
        tok_next = tok_cur;
        // first hit on the way back is the nearest older producer
        if (tok_cur.src1_used && !tok_cur.src1_found && valid_reg && has_dest_reg
                && dest_reg_reg == tok_cur.src1_reg) begin
            tok_next.src1_found    = 1'b1;
            tok_next.src1_producer = ENTRY_IDX_W'(CELL_INDEX);
        end
        if (tok_cur.src2_used && !tok_cur.src2_found && valid_reg && has_dest_reg
                && dest_reg_reg == tok_cur.src2_reg) begin
            tok_next.src2_found    = 1'b1;
            tok_next.src2_producer = ENTRY_IDX_W'(CELL_INDEX);
        end
        if (tok_cur.is_load && !tok_cur.mem_found && valid_reg && is_store_reg) begin
            tok_next.mem_found    = 1'b1;
            tok_next.mem_producer = ENTRY_IDX_W'(CELL_INDEX);
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/issue_window_dependency_tracker_core.sv
// Dependency lookup over a window of WINDOW_ENTRIES reorder-buffer entries, one cell
// per entry. A remove transaction (tuser high) clears the entry's valid mark and
// returns nothing. An add transaction starts a search token in the cell just older
// than the entry; the token steps one cell per cycle backward around the ring and
// records the nearest valid writer of each used source and, for a load, the nearest
// valid store. Once the token has passed the other WINDOW_ENTRIES-1 cells, the done
// state writes the entry and loads the result register, waiting there while the
// previous result has not been taken; the next transaction is taken after that.
// Input is accepted only while no search is running; the result register lets the
// next transaction in while a result waits on the master side.
module issue_window_dependency_tracker_core #(
    parameter int WINDOW_ENTRIES = iwdt_pkg::DEFAULT_WINDOW_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry[4:0] src1_used[5] src1_reg[12:6] src2_used[13] src2_reg[20:14]
    // dest_used[21] dest_reg[28:22] kind[30:29], bit 31 zero
    input  logic [31:0] s_tdata,
    // op[0]: 0 add, 1 remove
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // src1_found[0] src1_producer[5:1] src2_found[6] src2_producer[11:7]
    // mem_found[12] mem_producer[17:13], bits 23:18 zero
    output logic [23:0] m_tdata
);
    import iwdt_pkg::*;

    localparam int EW = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;
    localparam int CW = EW;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [EW-1:0]   self_reg, prev_reg, next_reg;
    token_t          start_tok_reg;
    logic            has_dest_reg;
    logic [REG_W-1:0] dest_reg_reg;
    logic            is_store_reg;

    logic [EW-1:0]   mod_tab [32];
    logic [EW-1:0]   in_self;
    logic            in_accept;
    logic            out_free;
    logic            inject_go;
    logic            done_load;
    logic            remove_go;
    logic [EW-1:0]   wr_idx;
    entry_wr_t       wr;
    token_t          tok_out [WINDOW_ENTRIES];
    token_t          fin_tok;
    token_t          fin_hold_reg;

    logic            m_tvalid_reg;
    logic [23:0]     m_tdata_reg;

    // entry field reduced into the window
    genvar gi;
    generate
        for (gi = 0; gi < 32; gi++) begin : g_mod
            assign mod_tab[gi] = EW'(gi % WINDOW_ENTRIES);
        end
    endgenerate

    assign in_self   = mod_tab[s_tdata[4:0]];
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_tuser == OP_ADD) begin
                    state_next = ST_SEARCH;
                    cnt_next   = '0;
                end
            end
            ST_SEARCH: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(WINDOW_ENTRIES - 2)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cnt_next = '0;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        inject_go = 1'b0;
        done_load = 1'b0;
        remove_go = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                remove_go = in_accept && s_tuser == OP_REMOVE;
            end
            ST_SEARCH: begin
                inject_go = (cnt_reg == '0);
            end
            ST_DONE: begin
                done_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && s_tuser == OP_ADD) begin
            self_reg <= in_self;
            prev_reg <= (in_self == '0) ? EW'(WINDOW_ENTRIES - 1) : in_self - 1'b1;
            next_reg <= (in_self == EW'(WINDOW_ENTRIES - 1)) ? '0 : in_self + 1'b1;
            start_tok_reg.src1_used     <= s_tdata[5];
            start_tok_reg.src1_reg      <= s_tdata[12:6];
            start_tok_reg.src2_used     <= s_tdata[13];
            start_tok_reg.src2_reg      <= s_tdata[20:14];
            start_tok_reg.is_load       <= (s_tdata[30:29] == KIND_LOAD);
            start_tok_reg.src1_found    <= 1'b0;
            start_tok_reg.src1_producer <= '0;
            start_tok_reg.src2_found    <= 1'b0;
            start_tok_reg.src2_producer <= '0;
            start_tok_reg.mem_found     <= 1'b0;
            start_tok_reg.mem_producer  <= '0;
            has_dest_reg <= s_tdata[21];
            dest_reg_reg <= s_tdata[28:22];
            is_store_reg <= (s_tdata[30:29] == KIND_STORE);
        end
    end

    assign wr_idx      = remove_go ? in_self : self_reg;
    assign wr.add      = done_load;
    assign wr.remove   = remove_go;
    assign wr.has_dest = has_dest_reg;
    assign wr.dest_reg = dest_reg_reg;
    assign wr.is_store = is_store_reg;

    generate
        for (gi = 0; gi < WINDOW_ENTRIES; gi++) begin : g_cell
            iwdt_cell #(
                .CELL_INDEX(gi)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .sel       (wr_idx == EW'(gi)),
                .wr        (wr),
                .inject    (inject_go && prev_reg == EW'(gi)),
                .start_tok (start_tok_reg),
                .tok_in    (tok_out[(gi + 1) % WINDOW_ENTRIES]),
                .tok_out   (tok_out[gi])
            );
        end
    endgenerate

    // after the last hop the token sits in the cell just newer than the entry
    // it moves on after the first done cycle, so a copy is kept while the result waits
    assign fin_tok = (cnt_reg == CW'(WINDOW_ENTRIES - 1)) ? tok_out[next_reg] : fin_hold_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE) begin
            fin_hold_reg <= fin_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_load) begin
            m_tdata_reg <= {6'd0,
                            fin_tok.mem_producer[4:0], fin_tok.mem_found,
                            fin_tok.src2_producer[4:0], fin_tok.src2_found,
                            fin_tok.src1_producer[4:0], fin_tok.src1_found};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
